[src/chs_pkg.sv]
// Package for the cosine hemisphere sampler: payload structs, datapath
// command and status types, fixed-point constants and the CORDIC angle table.
// No dependencies.
package chs_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int VEC_W         = 34;
  localparam int ACC_W         = 68;
  localparam int RNG_W         = 48;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_STEPS     = 31;
  localparam int CORDIC_STEPS  = 24;

  localparam logic [23:0] LCG_MUL_LO = 24'hECE66D;
  localparam logic [23:0] LCG_MUL_HI = 24'h0005DE;
  localparam logic [47:0] LCG_ADD    = 48'hB;
  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } chs_in_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] out_dir_x;
    logic signed [15:0] out_dir_y;
    logic signed [15:0] out_dir_z;
  } chs_out_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DOT, OP_FRAME, OP_LCG, OP_NSHR, OP_NSHL, OP_NSQ,
    OP_SQRT_INIT, OP_SQRT_STEP, OP_SQRT_SAVE, OP_DIV_INIT, OP_DIV_STEP,
    OP_DIV_SAVE, OP_SAVE_U, OP_CROSS, OP_COR_INIT, OP_COR_STEP, OP_COR_END,
    OP_CRSR, OP_DSUM, OP_OUT
  } chs_op_t;

  typedef enum logic [1:0] {
    SQ_NORM, SQ_R2S, SQ_Q
  } chs_sqsel_t;

  typedef struct packed {
    chs_op_t    op;
    logic [1:0] idx;
    logic [4:0] step;
    chs_sqsel_t sqsel;
  } chs_cmd_t;

  typedef struct packed {
    logic vzero;
    logic vbig;
    logic vsmall;
  } chs_sts_t;

  // Arc tangents of 2^-i in units of 2^-32 turns.
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[src/chs_ctrl.sv]
// Controller of the cosine hemisphere sampler: sequences the datapath
// operations for one transaction and owns both channel handshakes.
// Depends on chs_pkg.
module chs_ctrl import chs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  chs_sts_t sts,
  output chs_cmd_t cmd
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_DOT    = 20'h00002,
    S_FRAME  = 20'h00004,
    S_LCG    = 20'h00008,
    S_NSCALE = 20'h00010,
    S_NSQ    = 20'h00020,
    S_SQI    = 20'h00040,
    S_SQS    = 20'h00080,
    S_SQE    = 20'h00100,
    S_DIVI   = 20'h00200,
    S_DIVS   = 20'h00400,
    S_DIVE   = 20'h00800,
    S_NDONE  = 20'h01000,
    S_CROSS  = 20'h02000,
    S_CORI   = 20'h04000,
    S_CORS   = 20'h08000,
    S_CORE   = 20'h10000,
    S_CRSR   = 20'h20000,
    S_DSUM   = 20'h40000,
    S_OUT    = 20'h80000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [4:0] step_r, step_nxt;
  logic       pass_r, pass_nxt;
  chs_sqsel_t sqsel_r, sqsel_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    pass_nxt  = pass_r;
    sqsel_nxt = sqsel_r;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    cmd.step  = step_r;
    cmd.sqsel = sqsel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DOT;
          idx_nxt   = 2'd0;
        end
      end
      S_DOT: begin
        cmd.op = OP_DOT;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = S_FRAME;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_FRAME: begin
        cmd.op    = OP_FRAME;
        state_nxt = S_LCG;
        step_nxt  = 5'd0;
      end
      S_LCG: begin
        cmd.op = OP_LCG;
        if (step_r == 5'd2) begin
          step_nxt = 5'd0;
          if (idx_r == 2'd1) begin
            idx_nxt   = 2'd0;
            pass_nxt  = 1'b0;
            state_nxt = S_NSCALE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_NSCALE: begin
        // A zero vector stays zero; otherwise bring the largest component
        // into the top octave one shift at a time.
        if (sts.vzero) begin
          state_nxt = S_NDONE;
        end else if (sts.vbig) begin
          cmd.op = OP_NSHR;
        end else if (sts.vsmall) begin
          cmd.op = OP_NSHL;
        end else begin
          idx_nxt   = 2'd0;
          state_nxt = S_NSQ;
        end
      end
      S_NSQ: begin
        cmd.op = OP_NSQ;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          sqsel_nxt = SQ_NORM;
          state_nxt = S_SQI;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_SQI: begin
        cmd.op    = OP_SQRT_INIT;
        step_nxt  = 5'd0;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op = OP_SQRT_STEP;
        if (step_r == 5'(SQRT_STEPS - 1)) begin
          step_nxt  = 5'd0;
          state_nxt = S_SQE;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_SQE: begin
        cmd.op = OP_SQRT_SAVE;
        case (sqsel_r)
          SQ_NORM: begin
            idx_nxt   = 2'd0;
            state_nxt = S_DIVI;
          end
          SQ_R2S: begin
            sqsel_nxt = SQ_Q;
            state_nxt = S_SQI;
          end
          default: begin
            idx_nxt   = 2'd0;
            state_nxt = S_CRSR;
          end
        endcase
      end
      S_DIVI: begin
        cmd.op    = OP_DIV_INIT;
        step_nxt  = 5'd0;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.op = OP_DIV_STEP;
        if (step_r == 5'(DIV_STEPS - 1)) begin
          step_nxt  = 5'd0;
          state_nxt = S_DIVE;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_DIVE: begin
        cmd.op = OP_DIV_SAVE;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = S_NDONE;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_DIVI;
        end
      end
      S_NDONE: begin
        if (pass_r) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_SAVE_U;
          idx_nxt   = 2'd0;
          step_nxt  = 5'd0;
          state_nxt = S_CROSS;
        end
      end
      S_CROSS: begin
        cmd.op = OP_CROSS;
        if (step_r == 5'd1) begin
          step_nxt = 5'd0;
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            state_nxt = S_CORI;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_CORI: begin
        cmd.op    = OP_COR_INIT;
        step_nxt  = 5'd0;
        state_nxt = S_CORS;
      end
      S_CORS: begin
        cmd.op = OP_COR_STEP;
        if (step_r == 5'(CORDIC_STEPS - 1)) begin
          step_nxt  = 5'd0;
          state_nxt = S_CORE;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_CORE: begin
        cmd.op    = OP_COR_END;
        sqsel_nxt = SQ_R2S;
        state_nxt = S_SQI;
      end
      S_CRSR: begin
        cmd.op = OP_CRSR;
        if (idx_r == 2'd1) begin
          idx_nxt   = 2'd0;
          step_nxt  = 5'd0;
          state_nxt = S_DSUM;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_DSUM: begin
        cmd.op = OP_DSUM;
        if (step_r == 5'd2) begin
          step_nxt = 5'd0;
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            pass_nxt  = 1'b1;
            state_nxt = S_NSCALE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      step_r      <= 5'd0;
      pass_r      <= 1'b0;
      sqsel_r     <= SQ_NORM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      pass_r      <= pass_nxt;
      sqsel_r     <= sqsel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/chs_dp.sv]
// Datapath of the cosine hemisphere sampler: shared multiplier with
// accumulator, bit-serial square root and divider, CORDIC and the generator.
// Depends on chs_pkg; driven by chs_ctrl through chs_cmd_t.
module chs_dp import chs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [RNG_W-1:0]     cfg_wr_data,
  input  chs_in_t              in_data,
  input  chs_cmd_t             cmd,
  output chs_sts_t             sts,
  output chs_out_t             out_data
);

  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [VEC_W-1:0] ONE_V = VEC_W'(1) << FRAC_BITS;
  localparam logic signed [35:0] RND = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;
  localparam logic signed [35:0] LIM_HI =
    (FRAC_BITS >= 15) ? 36'sd32767 : (36'sd1 <<< FRAC_BITS);
  localparam logic signed [35:0] LIM_LO =
    (FRAC_BITS >= 15) ? -36'sd32768 : -(36'sd1 <<< FRAC_BITS);
  localparam logic signed [VEC_W-1:0] BIG_V   = VEC_W'(1) << 30;
  localparam logic signed [VEC_W-1:0] SMALL_V = VEC_W'(1) << 29;

  logic signed [16:0]       dv_r [3], dv_nxt [3];
  logic signed [16:0]       nv_r [3], nv_nxt [3];
  logic signed [31:0]       hit_r [3], hit_nxt [3];
  logic signed [VEC_W-1:0]  wv_r [3], wv_nxt [3];
  logic signed [VEC_W-1:0]  uv_r [3], uv_nxt [3];
  logic signed [VEC_W-1:0]  vv_r [3], vv_nxt [3];
  logic signed [VEC_W-1:0]  vec_r [3], vec_nxt [3];
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [RNG_W-1:0]         rng_r, rng_nxt;
  logic [15:0]              u1_r, u1_nxt, u2_r, u2_nxt;
  logic [62:0]              sq_n_r, sq_n_nxt, sq_res_r, sq_res_nxt, sq_bit_r, sq_bit_nxt;
  logic [31:0]              len_r, len_nxt, r2s_r, r2s_nxt, q_r, q_nxt;
  logic [31:0]              div_rem_r, div_rem_nxt;
  logic [30:0]              div_lo_r, div_lo_nxt, div_q_r, div_q_nxt;
  logic                     div_neg_r, div_neg_nxt;
  logic signed [VEC_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic                     cneg_r, cneg_nxt;
  logic signed [VEC_W-1:0]  cr_r, cr_nxt, sr_r, sr_nxt;
  chs_out_t                 out_r, out_nxt;

  logic signed [VEC_W-1:0]  mul_a, mul_b;
  logic signed [ACC_W-1:0]  prod;
  logic [1:0]               n1, n2;

  function automatic logic [1:0] next3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic signed [16:0] sat_in(input logic signed [15:0] x);
    logic signed [VEC_W-1:0] e;
    e = VEC_W'(x);
    if (e > ONE_V) begin
      e = ONE_V;
    end else if (e < -ONE_V) begin
      e = -ONE_V;
    end
    return e[16:0];
  endfunction

  function automatic logic signed [VEC_W-1:0] vabs(input logic signed [VEC_W-1:0] x);
    return x[VEC_W-1] ? -x : x;
  endfunction

  function automatic logic signed [15:0] to_port(input logic signed [VEC_W-1:0] d);
    logic signed [35:0] r;
    r = (36'(d) + RND) >>> SH;
    if (r > LIM_HI) begin
      r = LIM_HI;
    end else if (r < LIM_LO) begin
      r = LIM_LO;
    end
    return r[15:0];
  endfunction

  assign n1 = next3(cmd.idx);
  assign n2 = next3(n1);

  // Status for the scaling loop of a normalisation.
  always_comb begin
    sts.vzero  = 1'b1;
    sts.vbig   = 1'b0;
    sts.vsmall = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (vec_r[i] != '0) sts.vzero = 1'b0;
      if (vabs(vec_r[i]) >= BIG_V) sts.vbig = 1'b1;
      if (vabs(vec_r[i]) >= SMALL_V) sts.vsmall = 1'b0;
    end
  end

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_DOT: begin
        mul_a = VEC_W'(nv_r[cmd.idx]);
        mul_b = VEC_W'(dv_r[cmd.idx]);
      end
      OP_LCG: begin
        case (cmd.step)
          5'd0: begin
            mul_a = VEC_W'({1'b0, rng_r[23:0]});
            mul_b = VEC_W'({1'b0, LCG_MUL_LO});
          end
          5'd1: begin
            mul_a = VEC_W'({1'b0, rng_r[23:0]});
            mul_b = VEC_W'({1'b0, LCG_MUL_HI});
          end
          default: begin
            mul_a = VEC_W'({1'b0, rng_r[47:24]});
            mul_b = VEC_W'({1'b0, LCG_MUL_LO});
          end
        endcase
      end
      OP_NSQ: begin
        mul_a = vec_r[cmd.idx];
        mul_b = vec_r[cmd.idx];
      end
      OP_CROSS: begin
        if (cmd.step == 5'd0) begin
          mul_a = wv_r[n1];
          mul_b = uv_r[n2];
        end else begin
          mul_a = wv_r[n2];
          mul_b = uv_r[n1];
        end
      end
      OP_CRSR: begin
        mul_a = (cmd.idx == 2'd0) ? cx_r : cy_r;
        mul_b = VEC_W'({1'b0, r2s_r});
      end
      OP_DSUM: begin
        case (cmd.step)
          5'd0: begin
            mul_a = uv_r[cmd.idx];
            mul_b = cr_r;
          end
          5'd1: begin
            mul_a = vv_r[cmd.idx];
            mul_b = sr_r;
          end
          default: begin
            mul_a = wv_r[cmd.idx];
            mul_b = VEC_W'({1'b0, q_r});
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);

  always_comb begin
    logic signed [17:0]      w [3];
    logic signed [VEC_W-1:0] aw0;
    logic signed [ACC_W-1:0] lsum;
    logic [31:0]             t, tc;
    logic [29:0]             amag;
    logic [60:0]             num;
    logic [62:0]             sqs;
    logic [32:0]             dt;
    logic [16:0]             qrem;
    logic signed [VEC_W-1:0] shx, shy;
    logic signed [ACC_W-1:0] dsum;

    for (int i = 0; i < 3; i++) begin
      dv_nxt[i]  = dv_r[i];
      nv_nxt[i]  = nv_r[i];
      hit_nxt[i] = hit_r[i];
      wv_nxt[i]  = wv_r[i];
      uv_nxt[i]  = uv_r[i];
      vv_nxt[i]  = vv_r[i];
      vec_nxt[i] = vec_r[i];
      w[i]       = '0;
    end
    acc_nxt     = acc_r;
    rng_nxt     = rng_r;
    u1_nxt      = u1_r;
    u2_nxt      = u2_r;
    sq_n_nxt    = sq_n_r;
    sq_res_nxt  = sq_res_r;
    sq_bit_nxt  = sq_bit_r;
    len_nxt     = len_r;
    r2s_nxt     = r2s_r;
    q_nxt       = q_r;
    div_rem_nxt = div_rem_r;
    div_lo_nxt  = div_lo_r;
    div_q_nxt   = div_q_r;
    div_neg_nxt = div_neg_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    cz_nxt      = cz_r;
    cneg_nxt    = cneg_r;
    cr_nxt      = cr_r;
    sr_nxt      = sr_r;
    out_nxt     = out_r;
    aw0         = '0;
    lsum        = '0;
    t           = '0;
    tc          = '0;
    amag        = '0;
    num         = '0;
    sqs         = '0;
    dt          = '0;
    qrem        = '0;
    shx         = '0;
    shy         = '0;
    dsum        = '0;

    case (cmd.op)
      OP_LOAD: begin
        dv_nxt[0]  = sat_in(in_data.dir_x);
        dv_nxt[1]  = sat_in(in_data.dir_y);
        dv_nxt[2]  = sat_in(in_data.dir_z);
        nv_nxt[0]  = sat_in(in_data.normal_x);
        nv_nxt[1]  = sat_in(in_data.normal_y);
        nv_nxt[2]  = sat_in(in_data.normal_z);
        hit_nxt[0] = in_data.hit_x;
        hit_nxt[1] = in_data.hit_y;
        hit_nxt[2] = in_data.hit_z;
      end
      OP_DOT: begin
        acc_nxt = ((cmd.idx == 2'd0) ? '0 : acc_r) + prod;
      end
      OP_FRAME: begin
        // The normal is turned to face against the ray; a zero dot product
        // also turns it.
        for (int i = 0; i < 3; i++) begin
          w[i] = acc_r[ACC_W-1] ? 18'(nv_r[i]) : -18'(nv_r[i]);
          wv_nxt[i] = VEC_W'(w[i]) <<< SH;
        end
        aw0 = vabs(VEC_W'(w[0]));
        if (((aw0 <<< 3) + (aw0 <<< 1)) > ONE_V) begin
          vec_nxt[0] = VEC_W'(w[2]);
          vec_nxt[1] = '0;
          vec_nxt[2] = -VEC_W'(w[0]);
        end else begin
          vec_nxt[0] = VEC_W'(w[2]) - VEC_W'(w[1]);
          vec_nxt[1] = VEC_W'(w[0]) - VEC_W'(w[2]);
          vec_nxt[2] = VEC_W'(w[1]) - VEC_W'(w[0]);
        end
      end
      OP_LCG: begin
        // State times the multiplier plus the increment, modulo 2^48, from three partial products.
        case (cmd.step)
          5'd0: acc_nxt = prod;
          5'd1: acc_nxt = acc_r + (prod <<< 24);
          default: begin
            lsum    = acc_r + (prod <<< 24) + ACC_W'(LCG_ADD);
            rng_nxt = lsum[RNG_W-1:0];
            if (cmd.idx == 2'd0) begin
              u1_nxt = lsum[47:32];
            end else begin
              u2_nxt = lsum[47:32];
            end
          end
        endcase
      end
      OP_NSHR: begin
        for (int i = 0; i < 3; i++) vec_nxt[i] = vec_r[i] >>> 1;
      end
      OP_NSHL: begin
        for (int i = 0; i < 3; i++) vec_nxt[i] = vec_r[i] <<< 1;
      end
      OP_NSQ: begin
        acc_nxt = ((cmd.idx == 2'd0) ? '0 : acc_r) + prod;
      end
      OP_SQRT_INIT: begin
        qrem = 17'h10000 - 17'(u2_r);
        case (cmd.sqsel)
          SQ_NORM: sq_n_nxt = acc_r[62:0];
          SQ_R2S:  sq_n_nxt = 63'({u2_r, 44'd0});
          default: sq_n_nxt = 63'({qrem, 44'd0});
        endcase
        sq_res_nxt = '0;
        sq_bit_nxt = 63'd1 << 62;
      end
      OP_SQRT_STEP: begin
        sqs = sq_res_r + sq_bit_r;
        if (sq_n_r >= sqs) begin
          sq_n_nxt   = sq_n_r - sqs;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
      end
      OP_SQRT_SAVE: begin
        case (cmd.sqsel)
          SQ_NORM: len_nxt = sq_res_r[31:0];
          SQ_R2S:  r2s_nxt = sq_res_r[31:0];
          default: q_nxt   = sq_res_r[31:0];
        endcase
      end
      OP_DIV_INIT: begin
        // Component magnitude over the length, rounded half up, in Q1.30.
        amag        = 30'(vabs(vec_r[cmd.idx]));
        num         = {1'b0, amag, 30'd0} + 61'(len_r >> 1);
        div_rem_nxt = 32'(num[60:31]);
        div_lo_nxt  = num[30:0];
        div_q_nxt   = '0;
        div_neg_nxt = vec_r[cmd.idx][VEC_W-1];
      end
      OP_DIV_STEP: begin
        dt = {div_rem_r, div_lo_r[30]};
        if (dt >= {1'b0, len_r}) begin
          dt          = dt - {1'b0, len_r};
          div_q_nxt   = {div_q_r[29:0], 1'b1};
        end else begin
          div_q_nxt   = {div_q_r[29:0], 1'b0};
        end
        div_rem_nxt = dt[31:0];
        div_lo_nxt  = {div_lo_r[29:0], 1'b0};
      end
      OP_DIV_SAVE: begin
        vec_nxt[cmd.idx] = div_neg_r ? -VEC_W'({1'b0, div_q_r}) : VEC_W'({1'b0, div_q_r});
      end
      OP_SAVE_U: begin
        for (int i = 0; i < 3; i++) uv_nxt[i] = vec_r[i];
      end
      OP_CROSS: begin
        if (cmd.step == 5'd0) begin
          acc_nxt = prod;
        end else begin
          dsum            = acc_r - prod;
          acc_nxt         = dsum;
          vv_nxt[cmd.idx] = VEC_W'(dsum >>> 30);
        end
      end
      OP_COR_INIT: begin
        // Fold the angle into the right half plane and negate at the end.
        t  = {u1_r, 16'd0};
        tc = t + 32'h4000_0000;
        if (tc[31]) begin
          t        = t + 32'h8000_0000;
          cneg_nxt = 1'b1;
        end else begin
          cneg_nxt = 1'b0;
        end
        cz_nxt = VEC_W'(signed'(t));
        cx_nxt = CORDIC_GAIN;
        cy_nxt = '0;
      end
      OP_COR_STEP: begin
        shx = cx_r >>> cmd.step;
        shy = cy_r >>> cmd.step;
        if (!cz_r[VEC_W-1]) begin
          cx_nxt = cx_r - shy;
          cy_nxt = cy_r + shx;
          cz_nxt = cz_r - VEC_W'(atan_turn(cmd.step));
        end else begin
          cx_nxt = cx_r + shy;
          cy_nxt = cy_r - shx;
          cz_nxt = cz_r + VEC_W'(atan_turn(cmd.step));
        end
      end
      OP_COR_END: begin
        if (cneg_r) begin
          cx_nxt = -cx_r;
          cy_nxt = -cy_r;
        end
      end
      OP_CRSR: begin
        if (cmd.idx == 2'd0) begin
          cr_nxt = VEC_W'(prod >>> 30);
        end else begin
          sr_nxt = VEC_W'(prod >>> 30);
        end
      end
      OP_DSUM: begin
        case (cmd.step)
          5'd0: acc_nxt = prod;
          5'd1: acc_nxt = acc_r + prod;
          default: begin
            dsum             = acc_r + prod;
            acc_nxt          = dsum;
            vec_nxt[cmd.idx] = VEC_W'(dsum >>> 30);
          end
        endcase
      end
      OP_OUT: begin
        out_nxt.origin_x  = hit_r[0];
        out_nxt.origin_y  = hit_r[1];
        out_nxt.origin_z  = hit_r[2];
        out_nxt.out_dir_x = to_port(vec_r[0]);
        out_nxt.out_dir_y = to_port(vec_r[1]);
        out_nxt.out_dir_z = to_port(vec_r[2]);
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase

    if (cfg_wr_en) begin
      rng_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= '0;
    end else begin
      rng_r <= rng_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_r[i]  <= dv_nxt[i];
      nv_r[i]  <= nv_nxt[i];
      hit_r[i] <= hit_nxt[i];
      wv_r[i]  <= wv_nxt[i];
      uv_r[i]  <= uv_nxt[i];
      vv_r[i]  <= vv_nxt[i];
      vec_r[i] <= vec_nxt[i];
    end
    acc_r     <= acc_nxt;
    u1_r      <= u1_nxt;
    u2_r      <= u2_nxt;
    sq_n_r    <= sq_n_nxt;
    sq_res_r  <= sq_res_nxt;
    sq_bit_r  <= sq_bit_nxt;
    len_r     <= len_nxt;
    r2s_r     <= r2s_nxt;
    q_r       <= q_nxt;
    div_rem_r <= div_rem_nxt;
    div_lo_r  <= div_lo_nxt;
    div_q_r   <= div_q_nxt;
    div_neg_r <= div_neg_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cz_r      <= cz_nxt;
    cneg_r    <= cneg_nxt;
    cr_r      <= cr_nxt;
    sr_r      <= sr_nxt;
    out_r     <= out_nxt;
  end

  assign out_data = out_r;

endmodule

[src/cosine_hemisphere_sampler_unit.sv]
// Top level of the cosine hemisphere sampler: controller plus datapath.
// Depends on chs_pkg, chs_ctrl and chs_dp.
//
//   port group   direction  handshake          payload
//   in_          input      in_valid/in_stall  chs_in_t   (ray, normal, hit)
//   out_         output     out_valid/out_stall chs_out_t (origin, direction)
//   cfg_         input      cfg_wr_en          48-bit generator seed
//
// The time from acceptance of a transaction to a valid result is set by the bit-serial
// square root (32 steps, four uses), the divider (31 steps, six uses), the 24-step CORDIC
// and the scaling shifts of both normalisations.
// A zero normal skips the root and divide passes of both normalisations.
// Reset is synchronous and clears the controller and the generator state.
// The result is held in an output register, so a new transaction is taken
// while out_stall holds the previous result.
module cosine_hemisphere_sampler_unit import chs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  chs_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output chs_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [RNG_W-1:0] cfg_wr_data
);

  chs_cmd_t cmd;
  chs_sts_t sts;

  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  chs_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule
